/* hdl/mfdu_pkg.sv */
// Package for the motor feedback decode and unwrap unit.
// Widths, slot codes and reset values shared by the interfaces and the RTL.
// No dependencies.
`default_nettype none

package mfdu_pkg;

	localparam int ID_W        = 11;
	localparam int BYTE_W      = 8;
	localparam int SLOT_W      = 3;
	localparam int RAW_W       = 16;
	localparam int ANGLE_W     = 13;
	localparam int POS_W       = 32;
	localparam int ACCUM_WIDTH = 32;
	localparam int NUM_SPEED   = 3;
	localparam int NUM_MOTORS  = 4;

	localparam logic [ID_W-1:0]   BASE_ID_RESET = 11'd513;
	localparam logic [SLOT_W-1:0] SLOT_TORQUE   = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_NONE     = 3'd4;

	typedef logic [ID_W-1:0]          frame_id_t;
	typedef logic [BYTE_W-1:0]        data_byte_t;
	typedef logic [SLOT_W-1:0]        slot_t;
	typedef logic signed [RAW_W-1:0]  raw_t;
	typedef logic [ANGLE_W-1:0]       angle_t;
	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic [ACCUM_WIDTH-1:0]   accum_t;

endpackage : mfdu_pkg

`default_nettype wire

/* hdl/mfdu_if.sv */
// Valid/ready channel interfaces for frame requests and decoded results.
// Depends on mfdu_pkg.
`default_nettype none

interface mfdu_frame_if
	import mfdu_pkg::*;
	;
	logic       valid;
	logic       ready;
	frame_id_t  frame_id;
	data_byte_t byte_zero;
	data_byte_t byte_one;
	data_byte_t byte_two;
	data_byte_t byte_three;
	data_byte_t byte_four;
	data_byte_t byte_five;

	modport source (
		output valid, frame_id, byte_zero, byte_one, byte_two, byte_three,
		       byte_four, byte_five,
		input  ready
	);
	modport sink (
		input  valid, frame_id, byte_zero, byte_one, byte_two, byte_three,
		       byte_four, byte_five,
		output ready
	);
endinterface : mfdu_frame_if

interface mfdu_result_if
	import mfdu_pkg::*;
	;
	logic  valid;
	logic  ready;
	slot_t slot;
	raw_t  speed_a;
	raw_t  speed_b;
	raw_t  speed_c;
	raw_t  torque;
	pos_t  position;

	modport source (
		output valid, slot, speed_a, speed_b, speed_c, torque, position,
		input  ready
	);
	modport sink (
		input  valid, slot, speed_a, speed_b, speed_c, torque, position,
		output ready
	);
endinterface : mfdu_result_if

`default_nettype wire

/* hdl/motor_feedback_decode_unwrap_unit.sv */
// Motor feedback decode and multi-turn angle unwrap, top level.
// Input register, then result register; one request per cycle when results are not stalled.
// The only loop is the 32-bit position add per torque frame.
// Reset (arst_n low, asynchronous): stores, position and offset flag cleared, base_id = 0x201.
// Depends on mfdu_pkg and the interfaces in mfdu_if.sv.
`default_nettype none

module motor_feedback_decode_unwrap_unit
	import mfdu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        base_id_we,
	input  wire frame_id_t   base_id_wdata,
	mfdu_frame_if.sink       frame_in,
	mfdu_result_if.source    result_out
);

	// configuration
	frame_id_t base_id_q;

	// stage 1: captured request
	logic       valid_s1;
	frame_id_t  frame_id_s1;
	data_byte_t byte_zero_s1, byte_one_s1, byte_two_s1, byte_three_s1;
	data_byte_t byte_four_s1, byte_five_s1;

	// stage 2: result; the stores double as the output payload registers
	logic   valid_s2;
	slot_t  slot_s2;
	raw_t   speed_q [NUM_SPEED];
	raw_t   torque_q;
	angle_t last_angle_q;
	accum_t position_q;   // accumulator minus zero offset, kept as one register
	logic   offset_taken_q;

	logic                   advance;
	logic [ID_W:0]          id_diff;
	logic                   id_match;
	slot_t                  slot_c;
	angle_t                 angle_c;
	logic signed [ANGLE_W-1:0] delta_c;

	// Stage 2 loads when stage 1 holds a request and stage 2 is empty or its result is being taken.
	assign advance        = valid_s1 && (!valid_s2 || result_out.ready);
	assign frame_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= BASE_ID_RESET;
		end else if (base_id_we) begin
			base_id_q <= base_id_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.ready && frame_in.valid) begin
			frame_id_s1   <= frame_in.frame_id;
			byte_zero_s1  <= frame_in.byte_zero;
			byte_one_s1   <= frame_in.byte_one;
			byte_two_s1   <= frame_in.byte_two;
			byte_three_s1 <= frame_in.byte_three;
			byte_four_s1  <= frame_in.byte_four;
			byte_five_s1  <= frame_in.byte_five;
		end
	end

	// Slot match: id - base in 0..3 with no wrap past the top identifier.
	assign id_diff  = {1'b0, frame_id_s1} - {1'b0, base_id_q};
	assign id_match = (id_diff[ID_W:$clog2(NUM_MOTORS)] == '0);
	assign slot_c   = id_match ? SLOT_W'(id_diff[$clog2(NUM_MOTORS)-1:0]) : SLOT_NONE;

	// Angle unwrap: a 13-bit wrapping difference lands in -4096..4095, which is
	// exactly the +/-8192 correction on the full difference.
	assign angle_c = ANGLE_W'({byte_zero_s1, byte_one_s1});
	assign delta_c = $signed(angle_c - last_angle_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SPEED; i++) begin
				speed_q[i] <= '0;
			end
			torque_q       <= '0;
			last_angle_q   <= '0;
			position_q     <= '0;
			offset_taken_q <= 1'b0;
		end else if (advance) begin
			if (slot_c < SLOT_TORQUE) begin
				speed_q[slot_c[1:0]] <= {byte_two_s1, byte_three_s1};
			end else if (slot_c == SLOT_TORQUE) begin
				torque_q     <= {byte_four_s1, byte_five_s1};
				last_angle_q <= angle_c;
				// First torque frame fixes the zero offset: position stays 0.
				if (offset_taken_q) begin
					position_q <= position_q + ACCUM_WIDTH'(delta_c);
				end else begin
					offset_taken_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_s2 <= slot_c;
		end
	end

	assign result_out.valid    = valid_s2;
	assign result_out.slot     = slot_s2;
	assign result_out.speed_a  = speed_q[0];
	assign result_out.speed_b  = speed_q[1];
	assign result_out.speed_c  = speed_q[2];
	assign result_out.torque   = torque_q;
	// sign-extend or truncate the accumulator width to the reported width
	assign result_out.position = POS_W'($signed(position_q));

endmodule : motor_feedback_decode_unwrap_unit

`default_nettype wire

/* dv/motor_feedback_decode_unwrap_unit_tb.sv */
// Testbench for motor_feedback_decode_unwrap_unit: a table of directed frames, then random
// frames under changing valid/ready pressure, each result checked against its table row or a local decoder.
// Depends on mfdu_pkg, the channel interfaces in mfdu_if.sv and the RTL top level.
`timescale 1ns / 100ps

module motor_feedback_decode_unwrap_unit_tb;
	import mfdu_pkg::*;

	localparam int CLK_PERIOD       = 4;
	localparam int RESET_CYCLES     = 3;
	localparam int FRAMES_PER_PHASE = 200;
	localparam int HOLD_CYCLES      = 64;    // long receiver hold-off, fills the pipe
	localparam int DRAIN_CYCLES     = 8;
	localparam int STALL_LIMIT      = 2000;  // cycles with no handshake on either side
	localparam int KEEP_BASE        = -1;    // table row leaves base_id alone
	localparam int DELTA_W          = ANGLE_W + 2;
	localparam int HALF_TURN        = 1 << (ANGLE_W - 1);
	localparam int FULL_TURN        = 1 << ANGLE_W;

	typedef struct packed {
		frame_id_t  frame_id;
		data_byte_t byte_zero;
		data_byte_t byte_one;
		data_byte_t byte_two;
		data_byte_t byte_three;
		data_byte_t byte_four;
		data_byte_t byte_five;
	} frame_req_t;

	typedef struct packed {
		slot_t slot;
		raw_t  speed_a;
		raw_t  speed_b;
		raw_t  speed_c;
		raw_t  torque;
		pos_t  position;
	} feedback_t;

	typedef struct {
		int         base;
		frame_req_t req;
		bit         typed;
		feedback_t  golden;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      base_id_we;
	frame_id_t base_id_wdata;

	mfdu_frame_if  frame_bus ();
	mfdu_result_if result_bus ();

	motor_feedback_decode_unwrap_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_id_we    (base_id_we),
		.base_id_wdata (base_id_wdata),
		.frame_in      (frame_bus),
		.result_out    (result_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Decoder state, kept in step with the block at every accepted request.
	frame_id_t cur_base;
	raw_t      speed_latch [NUM_SPEED];
	raw_t      torque_latch;
	angle_t    prev_angle;
	accum_t    turn_count;
	accum_t    home_offset;
	bit        home_taken;

	feedback_t pending_results [$];
	stim_row_t stim_table [$];
	int        mismatches = 0;

	// Idle percentages per side; the receiver also honors a one-shot long hold.
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request = 1'b0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	// Decode one frame: update the latches, unwrap the angle on torque frames,
	// and return what the block must report for it.
	function automatic feedback_t decode_frame(frame_req_t f);
		feedback_t                 r;
		logic [ID_W:0]             gap;
		logic [15:0]               word;
		angle_t                    ang;
		logic signed [DELTA_W-1:0] delta;
		accum_t                    rel;
		gap    = {1'b0, f.frame_id} - {1'b0, cur_base};
		r.slot = SLOT_NONE;
		// no wrap past the top of the identifier space
		if (f.frame_id >= cur_base && gap < NUM_MOTORS)
			r.slot = slot_t'(gap);
		if (r.slot < SLOT_TORQUE) begin
			speed_latch[r.slot] = {f.byte_two, f.byte_three};
		end else if (r.slot == SLOT_TORQUE) begin
			word  = {f.byte_zero, f.byte_one};
			ang   = word[ANGLE_W-1:0];  // top three bits of byte zero dropped
			delta = $signed({2'b00, ang}) - $signed({2'b00, prev_angle});
			if (delta >= HALF_TURN)
				delta = delta - FULL_TURN;
			else if (delta < -HALF_TURN)
				delta = delta + FULL_TURN;
			turn_count   = turn_count + {{(ACCUM_WIDTH - DELTA_W){delta[DELTA_W-1]}}, delta};
			torque_latch = {f.byte_four, f.byte_five};
			prev_angle   = ang;
			// first torque frame after reset sets the zero point
			if (!home_taken) begin
				home_offset = turn_count;
				home_taken  = 1'b1;
			end
		end
		rel        = turn_count - home_offset;
		r.speed_a  = speed_latch[0];
		r.speed_b  = speed_latch[1];
		r.speed_c  = speed_latch[2];
		r.torque   = torque_latch;
		r.position = pos_t'($signed(rel));
		return r;
	endfunction

	function automatic void add_row(int base, int id, int b0, int b1, int b2, int b3, int b4,
			int b5, bit typed = 1'b0, int slot = 0, int sa = 0, int sb = 0, int sc = 0,
			int tq = 0, int pos = 0);
		stim_row_t row;
		row.base            = base;
		row.req             = {frame_id_t'(id), data_byte_t'(b0), data_byte_t'(b1),
		                       data_byte_t'(b2), data_byte_t'(b3), data_byte_t'(b4),
		                       data_byte_t'(b5)};
		row.typed           = typed;
		row.golden.slot     = slot_t'(slot);
		row.golden.speed_a  = raw_t'(sa);
		row.golden.speed_b  = raw_t'(sb);
		row.golden.speed_c  = raw_t'(sc);
		row.golden.torque   = raw_t'(tq);
		row.golden.position = pos_t'(pos);
		stim_table.push_back(row);
	endfunction

	// Random frame. Most requests hit the four decoded identifiers, torque frames most
	// often; the angle either jumps anywhere, creeps, or lands on the half-turn edges.
	function automatic frame_req_t rand_frame();
		frame_req_t f;
		int         kind;
		int         step;
		angle_t     ang;
		f    = frame_req_t'({$urandom, $urandom});
		kind = $urandom_range(99);
		if (kind < 15)
			f.frame_id = frame_id_t'($urandom_range(2047));
		else if (kind < 45)
			f.frame_id = frame_id_t'(cur_base + $urandom_range(2));
		else
			f.frame_id = frame_id_t'(cur_base + 3);
		case ($urandom_range(3))
			0: step = $urandom_range(FULL_TURN - 1);
			1: step = $urandom_range(200) - 100;
			2: step = HALF_TURN + $urandom_range(2) - 1;
			default: step = -HALF_TURN + $urandom_range(2) - 1;
		endcase
		ang         = prev_angle + angle_t'(step);
		f.byte_zero = {f.byte_zero[7:5], ang[ANGLE_W-1:8]};
		f.byte_one  = ang[7:0];
		return f;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one request; the expectation is queued at the edge it is accepted.
	// valid is left high on return so back-to-back requests need no extra edge.
	task automatic send_frame(frame_req_t f, bit typed, feedback_t golden);
		feedback_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			frame_bus.valid <= 1'b0;
			@(posedge clk);
		end
		frame_bus.valid      <= 1'b1;
		frame_bus.frame_id   <= f.frame_id;
		frame_bus.byte_zero  <= f.byte_zero;
		frame_bus.byte_one   <= f.byte_one;
		frame_bus.byte_two   <= f.byte_two;
		frame_bus.byte_three <= f.byte_three;
		frame_bus.byte_four  <= f.byte_four;
		frame_bus.byte_five  <= f.byte_five;
		do
			@(posedge clk);
		while (!frame_bus.ready);
		predicted = decode_frame(f);
		pending_results.push_back(typed ? golden : predicted);
	endtask

	// base_id changes only with the block drained.
	task automatic set_base(frame_id_t value);
		frame_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		base_id_we    <= 1'b1;
		base_id_wdata <= value;
		@(posedge clk);
		base_id_we    <= 1'b0;
		cur_base       = value;
	endtask

	// Receiver: random ready, a long hold-off on request, and the result check.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no request pending, slot %0d", result_bus.slot);
					mismatches++;
				end else begin
					feedback_t want;
					want = pending_results.pop_front();
					check_field("slot", want.slot, result_bus.slot);
					check_field("speed_a", want.speed_a, result_bus.speed_a);
					check_field("speed_b", want.speed_b, result_bus.speed_b);
					check_field("speed_c", want.speed_c, result_bus.speed_c);
					check_field("torque", want.torque, result_bus.torque);
					check_field("position", want.position, result_bus.position);
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: a run with no handshake for too long has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		base_id_we           = 1'b0;
		base_id_wdata        = BASE_ID_RESET;
		frame_bus.valid      = 1'b0;
		frame_bus.frame_id   = '0;
		frame_bus.byte_zero  = '0;
		frame_bus.byte_one   = '0;
		frame_bus.byte_two   = '0;
		frame_bus.byte_three = '0;
		frame_bus.byte_four  = '0;
		frame_bus.byte_five  = '0;
		result_bus.ready     = 1'b0;

		cur_base     = BASE_ID_RESET;
		speed_latch  = '{default: '0};
		torque_latch = '0;
		prev_angle   = '0;
		turn_count   = '0;
		home_offset  = '0;
		home_taken   = 1'b0;

		// Directed table, reset base 0x201. Typed rows: state straight after reset,
		// speed and torque extremes, the first torque frame giving position 0 and a one-count step.
		add_row(KEEP_BASE, 'h000, 0, 0, 0, 0, 0, 0, 1, 4, 0, 0, 0, 0, 0);
		add_row(KEEP_BASE, 'h201, 0, 0, 'h7F, 'hFF, 0, 0, 1, 0, 32767, 0, 0, 0, 0);
		add_row(KEEP_BASE, 'h202, 0, 0, 'h80, 'h00, 0, 0, 1, 1, 32767, -32768, 0, 0, 0);
		add_row(KEEP_BASE, 'h203, 0, 0, 'hFF, 'hFF, 0, 0, 1, 2, 32767, -32768, -1, 0, 0);
		// angle 8191 against reset angle 0 unwraps to -1, offset taken on this frame
		add_row(KEEP_BASE, 'h204, 'hFF, 'hFF, 0, 0, 'h80, 'h00,
			1, 3, 32767, -32768, -1, -32768, 0);
		// angle 0 with junk in the top bits of byte zero: one count forward
		add_row(KEEP_BASE, 'h204, 'hE0, 'h00, 0, 0, 'h7F, 'hFF,
			1, 3, 32767, -32768, -1, 32767, 1);
		// half-turn boundaries in both directions
		add_row(KEEP_BASE, 'h204, 'h0F, 'hFF, 1, 2, 3, 4);
		add_row(KEEP_BASE, 'h204, 'h00, 'h00, 5, 6, 7, 8);
		add_row(KEEP_BASE, 'h204, 'h10, 'h00, 9, 10, 11, 12);
		add_row(KEEP_BASE, 'h204, 'h00, 'h00, 13, 14, 15, 16);
		add_row(KEEP_BASE, 'h204, 'h10, 'h01, 17, 18, 19, 20);
		add_row(KEEP_BASE, 'h204, 'h00, 'h00, 21, 22, 23, 24);
		// unrecognized identifiers: top of range, just below and just above the window
		add_row(KEEP_BASE, 'h7FF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);
		add_row(KEEP_BASE, 'h200, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA);
		add_row(KEEP_BASE, 'h205, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55);
		// lowest base
		add_row(0, 0, 'h00, 'h00, 'h12, 'h34, 0, 0);
		add_row(KEEP_BASE, 3, 'h1A, 'hBC, 0, 0, 'h01, 'h23);
		add_row(KEEP_BASE, 4, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);
		// highest base: the window ends exactly at identifier 2047
		add_row(2044, 2047, 'h01, 'h23, 0, 0, 'hFE, 'hDC);
		add_row(KEEP_BASE, 2044, 0, 0, 'hC3, 'h5A, 0, 0);
		add_row(KEEP_BASE, 2046, 0, 0, 'h3C, 'hA5, 0, 0);
		add_row(KEEP_BASE, 2043, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);

		send_idle_pct = 28;
		recv_idle_pct = 47;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].base != KEEP_BASE)
				set_base(frame_id_t'(stim_table[i].base));
			send_frame(stim_table[i].req, stim_table[i].typed, stim_table[i].golden);
		end

		// Random phases: receiver-heavy gaps, then sender-heavy gaps, then none at all.
		for (int phase = 0; phase < 3; phase++) begin
			set_base(frame_id_t'($urandom_range(2044)));
			send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 47 : 0;
			recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 28 : 0;
			// with both sides eager, hold the receiver off so the block backs up
			if (phase == 2)
				hold_request = 1'b1;
			repeat (FRAMES_PER_PHASE)
				send_frame(rand_frame(), 1'b0, '0);
		end

		frame_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule : motor_feedback_decode_unwrap_unit_tb

/* sim.f */
hdl/mfdu_pkg.sv
hdl/mfdu_if.sv
hdl/motor_feedback_decode_unwrap_unit.sv
dv/motor_feedback_decode_unwrap_unit_tb.sv
